### hw/rtl/dnrg_pkg.sv
// Package for the decimal glyph emitter: microcode table, step/op/condition
// codes, the 3x5 font rectangle table and the rectangle record type.
// No dependencies.
`timescale 1ns / 1ps

package dnrg_pkg;

  localparam int unsigned MaxDigitsDef = 5;

  // v / 10 == (v * Recip10) >> Recip10Shift for every 16-bit v
  localparam logic [15:0] Recip10      = 16'hCCCD;
  localparam int unsigned Recip10Shift = 19;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_DIV,
    STEP_EMIT
  } step_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DIV,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_START,
    COND_MORE,
    COND_DONE
  } cond_e;

  // if cond holds go to jump, else go to next
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e jump;
    step_e next;
  } uword_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [2:0] dy;
    logic [1:0] w;
    logic [2:0] h;
  } cell_rect_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        glyph_end;
  } rect_t;

  function automatic uword_t ucode(step_e pc);
    uword_t uw;
    unique case (pc)
      STEP_IDLE: uw = '{op: OP_LOAD, cond: COND_START, jump: STEP_DIV,  next: STEP_IDLE};
      STEP_DIV:  uw = '{op: OP_DIV,  cond: COND_MORE,  jump: STEP_DIV,  next: STEP_EMIT};
      STEP_EMIT: uw = '{op: OP_EMIT, cond: COND_DONE,  jump: STEP_IDLE, next: STEP_EMIT};
      default:   uw = '{op: OP_LOAD, cond: COND_START, jump: STEP_IDLE, next: STEP_IDLE};
    endcase
    return uw;
  endfunction

  function automatic logic [5:0] glyph_start(logic [3:0] d);
    logic [5:0] s;
    case (d)
      4'd0:    s = 6'd0;
      4'd1:    s = 6'd4;
      4'd2:    s = 6'd8;
      4'd3:    s = 6'd13;
      4'd4:    s = 6'd17;
      4'd5:    s = 6'd20;
      4'd6:    s = 6'd25;
      4'd7:    s = 6'd31;
      4'd8:    s = 6'd33;
      4'd9:    s = 6'd38;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] glyph_count(logic [3:0] d);
    logic [2:0] c;
    case (d)
      4'd0, 4'd1, 4'd3:             c = 3'd4;
      4'd2, 4'd5, 4'd8, 4'd9:       c = 3'd5;
      4'd4:                         c = 3'd3;
      4'd6:                         c = 3'd6;
      4'd7:                         c = 3'd2;
      default:                      c = 3'd1;
    endcase
    return c;
  endfunction

  function automatic cell_rect_t glyph_rect(logic [5:0] idx);
    cell_rect_t r;
    case (idx)
      // 0
      6'd0:  r = '{2'd0, 3'd0, 2'd1, 3'd5};
      6'd1:  r = '{2'd1, 3'd0, 2'd1, 3'd1};
      6'd2:  r = '{2'd2, 3'd0, 2'd1, 3'd5};
      6'd3:  r = '{2'd1, 3'd4, 2'd1, 3'd1};
      // 1
      6'd4:  r = '{2'd1, 3'd0, 2'd1, 3'd5};
      6'd5:  r = '{2'd0, 3'd1, 2'd1, 3'd1};
      6'd6:  r = '{2'd0, 3'd4, 2'd1, 3'd1};
      6'd7:  r = '{2'd2, 3'd4, 2'd1, 3'd1};
      // 2
      6'd8:  r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd9:  r = '{2'd2, 3'd1, 2'd1, 3'd1};
      6'd10: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      6'd11: r = '{2'd0, 3'd3, 2'd1, 3'd1};
      6'd12: r = '{2'd0, 3'd4, 2'd3, 3'd1};
      // 3
      6'd13: r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd14: r = '{2'd2, 3'd1, 2'd1, 3'd3};
      6'd15: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      6'd16: r = '{2'd0, 3'd4, 2'd3, 3'd1};
      // 4
      6'd17: r = '{2'd0, 3'd0, 2'd1, 3'd2};
      6'd18: r = '{2'd2, 3'd0, 2'd1, 3'd5};
      6'd19: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      // 5
      6'd20: r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd21: r = '{2'd0, 3'd1, 2'd1, 3'd2};
      6'd22: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      6'd23: r = '{2'd2, 3'd3, 2'd1, 3'd1};
      6'd24: r = '{2'd0, 3'd4, 2'd3, 3'd1};
      // 6
      6'd25: r = '{2'd2, 3'd0, 2'd1, 3'd1};
      6'd26: r = '{2'd0, 3'd1, 2'd1, 3'd3};
      6'd27: r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd28: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      6'd29: r = '{2'd0, 3'd4, 2'd3, 3'd1};
      6'd30: r = '{2'd2, 3'd3, 2'd1, 3'd1};
      // 7
      6'd31: r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd32: r = '{2'd2, 3'd1, 2'd1, 3'd4};
      // 8
      6'd33: r = '{2'd0, 3'd0, 2'd1, 3'd5};
      6'd34: r = '{2'd2, 3'd0, 2'd1, 3'd5};
      6'd35: r = '{2'd1, 3'd0, 2'd1, 3'd1};
      6'd36: r = '{2'd1, 3'd2, 2'd1, 3'd1};
      6'd37: r = '{2'd1, 3'd4, 2'd1, 3'd1};
      // 9
      6'd38: r = '{2'd0, 3'd0, 2'd3, 3'd1};
      6'd39: r = '{2'd0, 3'd2, 2'd3, 3'd1};
      6'd40: r = '{2'd0, 3'd1, 2'd1, 3'd1};
      6'd41: r = '{2'd2, 3'd1, 2'd1, 3'd3};
      6'd42: r = '{2'd0, 3'd4, 2'd3, 3'd1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/dnrg_glyph.sv
// Font lookup and placement of one rectangle of a digit glyph.
// Depends on dnrg_pkg (font tables, rect_t).
`timescale 1ns / 1ps

module dnrg_glyph import dnrg_pkg::*; (
  input  logic [3:0]  digit_i,
  input  logic [2:0]  rect_idx_i,
  input  logic [7:0]  scale_i,
  input  logic [15:0] base_x_i,
  input  logic [15:0] base_y_i,
  output rect_t       rect_o
);

  cell_rect_t  font_rect;
  logic [5:0]  rom_idx;
  logic [10:0] dx_s, dy_s, w_s, h_s;

  always_comb begin
    rom_idx   = glyph_start(digit_i) + 6'(rect_idx_i);
    font_rect = glyph_rect(rom_idx);
    dx_s      = 11'(font_rect.dx) * 11'(scale_i);
    dy_s      = 11'(font_rect.dy) * 11'(scale_i);
    w_s       = 11'(font_rect.w)  * 11'(scale_i);
    h_s       = 11'(font_rect.h)  * 11'(scale_i);
    rect_o.x = base_x_i + 16'(dx_s);
    rect_o.y = base_y_i + 16'(dy_s);
    rect_o.w = 16'(w_s);
    rect_o.h = 16'(h_s);
    rect_o.glyph_end = (rect_idx_i == glyph_count(digit_i) - 3'd1);
  end

endmodule

### hw/rtl/decimal_number_rect_glyph_emitter.sv
// After start is taken, the one-digit-per-cycle divide-by-10 step of the
// microcode splits the value into its decimal digits; the single rectangle
// emit step then strobes one rectangle per cycle, 2..6 per digit. A new
// number is taken only once the last one is through. busy_o falls as the last
// rectangle shows, so the next start may land on that edge. Reset is async
// active low. Depends on dnrg_pkg and dnrg_glyph.
`timescale 1ns / 1ps

module decimal_number_rect_glyph_emitter import dnrg_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] value_i,
  input  logic [15:0] ink_color_i,
  input  logic [7:0]  scale_i,
  output logic        rect_valid_o,
  output logic [15:0] rect_x_o,
  output logic [15:0] rect_y_o,
  output logic [15:0] rect_w_o,
  output logic [15:0] rect_h_o,
  output logic [15:0] rect_color_o,
  output logic        last_rect_o
);

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  step_e       pc_q, pc_d;
  uword_t      uw;
  logic        cond;

  logic [15:0] v_q, base_x_q, pos_y_q, color_q;
  logic [7:0]  scale_q;
  logic [3:0]  rev_q [MAX_DIGITS];
  logic [IdxW-1:0] dig_q;
  logic [2:0]  r_q;

  logic [31:0] prod;
  logic [15:0] quot, rem16;
  logic        more;
  rect_t       rect;

  logic        valid_q, last_q;
  logic [15:0] x_q, y_q, w_q, h_q, col_q;

  // divide by 10 through the reciprocal
  always_comb begin
    prod  = 32'(v_q) * 32'(Recip10);
    quot  = 16'(prod >> Recip10Shift);
    rem16 = v_q - {quot[12:0], 3'b000} - {quot[14:0], 1'b0};
    more  = (quot != 16'd0) && ((CntW'(dig_q) + CntW'(1)) < CntW'(MAX_DIGITS));
  end

  dnrg_glyph u_glyph (
    .digit_i    (rev_q[dig_q]),
    .rect_idx_i (r_q),
    .scale_i    (scale_q),
    .base_x_i   (base_x_q),
    .base_y_i   (pos_y_q),
    .rect_o     (rect)
  );

  // sequencer
  always_comb begin
    uw = ucode(pc_q);
    unique case (uw.cond)
      COND_START: cond = start_i;
      COND_MORE:  cond = more;
      COND_DONE:  cond = rect.glyph_end && (dig_q == '0);
      default:    cond = 1'b0;
    endcase
    pc_d = cond ? uw.jump : uw.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= STEP_IDLE;
      dig_q   <= '0;
      r_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      valid_q <= (uw.op == OP_EMIT);
      last_q  <= (uw.op == OP_EMIT) && cond;
      unique case (uw.op)
        OP_LOAD: begin
          if (start_i) begin
            dig_q <= '0;
            r_q   <= '0;
          end
        end
        OP_DIV: begin
          // on the final digit dig_q stays at the top digit's index
          if (more) dig_q <= dig_q + IdxW'(1);
        end
        OP_EMIT: begin
          if (rect.glyph_end) begin
            r_q <= '0;
            // stays at zero after the lowest digit so the digit index stays in range
            if (dig_q != '0) dig_q <= dig_q - IdxW'(1);
          end else begin
            r_q <= r_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (start_i) begin
          v_q      <= value_i;
          base_x_q <= pos_x_i;
          pos_y_q  <= pos_y_i;
          color_q  <= ink_color_i;
          scale_q  <= scale_i;
        end
      end
      OP_DIV: begin
        rev_q[dig_q] <= rem16[3:0];
        v_q          <= quot;
      end
      OP_EMIT: begin
        x_q   <= rect.x;
        y_q   <= rect.y;
        w_q   <= rect.w;
        h_q   <= rect.h;
        col_q <= color_q;
        if (rect.glyph_end) base_x_q <= base_x_q + {6'b0, scale_q, 2'b00};
      end
      default: ;
    endcase
  end

  assign busy_o       = (pc_q != STEP_IDLE);
  assign rect_valid_o = valid_q;
  assign last_rect_o  = last_q;
  assign rect_x_o     = x_q;
  assign rect_y_o     = y_q;
  assign rect_w_o     = w_q;
  assign rect_h_o     = h_q;
  assign rect_color_o = col_q;

endmodule

### hw/rtl/dnrg_checker.sv
// Port-level checks for the decimal glyph emitter, bound to the top level.
// Depends on decimal_number_rect_glyph_emitter's port list only.
`timescale 1ns / 1ps

module dnrg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic rect_valid_o,
  input logic last_rect_o
);

  // a start taken while idle raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> $past(busy_o))
    else $error("rect strobe without prior busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_rect_o |-> rect_valid_o)
    else $error("last marker without strobe");

  // more rectangles of this item pending: must still be busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rect_valid_o && !last_rect_o) |-> busy_o)
    else $error("idle before last rect");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (rect_valid_o && last_rect_o))
    else $error("busy dropped without last rect");

endmodule

bind decimal_number_rect_glyph_emitter dnrg_checker u_dnrg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .rect_valid_o (rect_valid_o),
  .last_rect_o  (last_rect_o)
);

### tb/sv/tb_decimal_number_rect_glyph_emitter.sv
// Self-checking testbench for decimal_number_rect_glyph_emitter: directed table,
// then random numbers with and without sender idling, all rectangles checked in order.
// Depends on dnrg_pkg (digit limit) and the emitter RTL.
`timescale 1ns / 1ps

module tb_decimal_number_rect_glyph_emitter;
  import dnrg_pkg::MaxDigitsDef;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned NUM_DIR = 20;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
    logic        last;
  } rect_exp_t;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] val;
    logic [15:0] color;
    logic [7:0]  scale;
    logic [3:0]  known_first;
    logic [3:0]  known_cnt;  // 0: expectation comes from the predictor
  } dir_row_t;

  // 3x5 font, one cell rect per entry as {dx, dy, w, h} nibbles
  localparam logic [0:42][15:0] FONT_CELLS = {
    16'h0015, 16'h1011, 16'h2015, 16'h1411,                 // 0
    16'h1015, 16'h0111, 16'h0411, 16'h2411,                 // 1
    16'h0031, 16'h2111, 16'h0231, 16'h0311, 16'h0431,       // 2
    16'h0031, 16'h2113, 16'h0231, 16'h0431,                 // 3
    16'h0012, 16'h2015, 16'h0231,                           // 4
    16'h0031, 16'h0112, 16'h0231, 16'h2311, 16'h0431,       // 5
    16'h2011, 16'h0113, 16'h0031, 16'h0231, 16'h0431, 16'h2311, // 6
    16'h0031, 16'h2114,                                     // 7
    16'h0015, 16'h2015, 16'h1011, 16'h1211, 16'h1411,       // 8
    16'h0031, 16'h0231, 16'h0111, 16'h2113, 16'h0431        // 9
  };
  localparam logic [0:9][5:0] GLYPH_FIRST = {
    6'd0, 6'd4, 6'd8, 6'd13, 6'd17, 6'd20, 6'd25, 6'd31, 6'd33, 6'd38
  };
  localparam logic [0:9][2:0] GLYPH_LEN = {
    3'd4, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd6, 3'd2, 3'd5, 3'd5
  };

  // hand-worked rectangles: zero at zero scale, a seven at unit scale,
  // a one at the largest scale
  localparam rect_exp_t [0:9] KNOWN_RECTS = {
    {16'h1234, 16'h5678, 16'd0, 16'd0, 16'hFFFF, 1'b0},
    {16'h1234, 16'h5678, 16'd0, 16'd0, 16'hFFFF, 1'b0},
    {16'h1234, 16'h5678, 16'd0, 16'd0, 16'hFFFF, 1'b0},
    {16'h1234, 16'h5678, 16'd0, 16'd0, 16'hFFFF, 1'b1},
    {16'd0,    16'd0,    16'd3, 16'd1, 16'h0000, 1'b0},
    {16'd2,    16'd1,    16'd1, 16'd4, 16'h0000, 1'b1},
    {16'd255,  16'd0,    16'd255, 16'd1275, 16'hA5A5, 1'b0},
    {16'd0,    16'd255,  16'd255, 16'd255,  16'hA5A5, 1'b0},
    {16'd0,    16'd1020, 16'd255, 16'd255,  16'hA5A5, 1'b0},
    {16'd510,  16'd1020, 16'd255, 16'd255,  16'hA5A5, 1'b1}
  };

  localparam dir_row_t [0:NUM_DIR-1] DIR_ROWS = {
    {16'h1234, 16'h5678, 16'd0,     16'hFFFF, 8'd0,   4'd0, 4'd4},
    {16'h0000, 16'h0000, 16'd7,     16'h0000, 8'd1,   4'd4, 4'd2},
    {16'h0000, 16'h0000, 16'd1,     16'hA5A5, 8'd255, 4'd6, 4'd4},
    {16'hFFFF, 16'hFFFF, 16'd65535, 16'h0000, 8'd255, 4'd0, 4'd0},
    {16'h0010, 16'h0020, 16'd12345, 16'h07E0, 8'd1,   4'd0, 4'd0},
    {16'h0100, 16'h0200, 16'd6789,  16'hF800, 8'd2,   4'd0, 4'd0},
    {16'h0003, 16'h0005, 16'd10000, 16'h001F, 8'd3,   4'd0, 4'd0},
    {16'h0000, 16'h0000, 16'd0,     16'h1234, 8'd1,   4'd0, 4'd0},
    {16'h4000, 16'h0040, 16'd9,     16'hFFFF, 8'd7,   4'd0, 4'd0},
    {16'hABCD, 16'hDCBA, 16'd65535, 16'h8001, 8'd0,   4'd0, 4'd0},
    {16'h8000, 16'h8000, 16'd4,     16'h7FFE, 8'd128, 4'd0, 4'd0},
    {16'hFFF0, 16'hFFF8, 16'd58,    16'h0F0F, 8'd16,  4'd0, 4'd0},
    {16'h0001, 16'h0002, 16'd60,    16'h5555, 8'd1,   4'd0, 4'd0},
    {16'hFF00, 16'hFE00, 16'd99,    16'hAAAA, 8'd255, 4'd0, 4'd0},
    {16'h7FFF, 16'h7FFF, 16'd1,     16'h0001, 8'd1,   4'd0, 4'd0},
    {16'h0400, 16'h0300, 16'd32768, 16'hC3C3, 8'd85,  4'd0, 4'd0},
    {16'h0000, 16'hFFFF, 16'd10,    16'h3C3C, 8'd1,   4'd0, 4'd0},
    {16'h1111, 16'h2222, 16'd55555, 16'h9999, 8'd4,   4'd0, 4'd0},
    {16'hF000, 16'h0F00, 16'd43210, 16'h6666, 8'd9,   4'd0, 4'd0},
    {16'h0FFF, 16'hF000, 16'd8,     16'hFF00, 8'd2,   4'd0, 4'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] value_i = '0;
  logic [15:0] ink_color_i = '0;
  logic [7:0]  scale_i = '0;
  logic        rect_valid_o;
  logic [15:0] rect_x_o;
  logic [15:0] rect_y_o;
  logic [15:0] rect_w_o;
  logic [15:0] rect_h_o;
  logic [15:0] rect_color_o;
  logic        last_rect_o;

  rect_exp_t pending_rects[$];
  int unsigned error_count = 0;
  int unsigned numbers_sent = 0;
  int unsigned rects_seen = 0;
  int unsigned cycle_count = 0;

  decimal_number_rect_glyph_emitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .value_i     (value_i),
    .ink_color_i (ink_color_i),
    .scale_i     (scale_i),
    .rect_valid_o(rect_valid_o),
    .rect_x_o    (rect_x_o),
    .rect_y_o    (rect_y_o),
    .rect_w_o    (rect_w_o),
    .rect_h_o    (rect_h_o),
    .rect_color_o(rect_color_o),
    .last_rect_o (last_rect_o)
  );

  always #5 clk_i = ~clk_i;

  // Rectangles a number draws: digits MSB first, each glyph in font order.
  function automatic void predict_number_rects(input logic [15:0] px, py, val, color,
                                               input logic [7:0] scale);
    logic [3:0]  digs [10];
    logic [31:0] v;
    logic [31:0] base_x;
    logic [3:0]  d;
    logic [15:0] font_cell;
    rect_exp_t   e;
    int          n;
    v = 32'(val);
    n = 0;
    do begin
      digs[n] = 4'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < MaxDigitsDef);
    for (int i = 0; i < n; i++) begin
      d = digs[n - 1 - i];
      base_x = px + i * 4 * scale;
      for (int r = 0; r < GLYPH_LEN[d]; r++) begin
        font_cell = FONT_CELLS[GLYPH_FIRST[d] + r];
        e.x = 16'(base_x + font_cell[15:12] * scale);
        e.y = py + font_cell[11:8] * scale;
        e.w = font_cell[7:4] * scale;
        e.h = font_cell[3:0] * scale;
        e.color = color;
        e.last = (i == n - 1) && (r == GLYPH_LEN[d] - 1);
        pending_rects.push_back(e);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Present a number and hold it until start is taken; start stays high on return.
  task automatic send_number(input logic [15:0] px, py, val, color, input logic [7:0] scale,
                             input int known_first, input int known_cnt);
    start_i     <= 1'b1;
    pos_x_i     <= px;
    pos_y_i     <= py;
    value_i     <= val;
    ink_color_i <= color;
    scale_i     <= scale;
    do @(posedge clk_i); while (busy_o);
    numbers_sent++;
    if (known_cnt > 0) begin
      for (int k = 0; k < known_cnt; k++) pending_rects.push_back(KNOWN_RECTS[known_first + k]);
    end else begin
      predict_number_rects(px, py, val, color, scale);
    end
  endtask

  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rects.size() != 0) @(posedge clk_i);
  endtask

  // Random numbers; idle_pct is the chance of a sender gap before each item.
  task automatic random_numbers(input int count, input int idle_pct);
    logic [15:0] val;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  scale;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < idle_pct) begin
        hold_off($urandom_range(1, 35));
      end
      case ($urandom_range(9))
        0, 1, 2: val = 16'($urandom_range(99));
        3, 4:    val = 16'($urandom_range(65535, 10000));
        default: val = 16'($urandom_range(65535));
      endcase
      scale = ($urandom_range(9) < 6) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
      px = 16'($urandom_range(65535));
      py = 16'($urandom_range(65535));
      // push some numbers against the coordinate wrap
      if ($urandom_range(4) == 0) begin
        px = 16'hFFFF - 16'($urandom_range(300));
        py = 16'hFFFF - 16'($urandom_range(300));
      end
      send_number(px, py, val, 16'($urandom_range(65535)), scale, 0, 0);
    end
  endtask

  always @(posedge clk_i) begin
    rect_exp_t want;
    if (rst_ni && rect_valid_o) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected rect: expected none, got x=%h y=%h w=%h h=%h c=%h l=%b",
                 $time, rect_x_o, rect_y_o, rect_w_o, rect_h_o, rect_color_o, last_rect_o);
        error_count++;
      end else begin
        want = pending_rects.pop_front();
        rects_seen++;
        check_field("rect_x", want.x, rect_x_o);
        check_field("rect_y", want.y, rect_y_o);
        check_field("rect_w", want.w, rect_w_o);
        check_field("rect_h", want.h, rect_h_o);
        check_field("rect_color", want.color, rect_color_o);
        check_field("last_rect", {15'd0, want.last}, {15'd0, last_rect_o});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rects outstanding", cycle_count,
               pending_rects.size());
      $display("decimal_number_rect_glyph_emitter regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_number(DIR_ROWS[i].px, DIR_ROWS[i].py, DIR_ROWS[i].val, DIR_ROWS[i].color,
                  DIR_ROWS[i].scale, DIR_ROWS[i].known_first, DIR_ROWS[i].known_cnt);
    end
    wait_drained();

    random_numbers(140, 22);
    wait_drained();
    random_numbers(140, 70);
    wait_drained();
    random_numbers(130, 0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d numbers (directed extremes, zero value/scale, wrap, all digits)",
             numbers_sent);
    $display("checked %0d rectangles, %0d mismatches", rects_seen, error_count);
    if (error_count == 0 && pending_rects.size() == 0) begin
      $display("decimal_number_rect_glyph_emitter regression: pass");
    end else begin
      $display("decimal_number_rect_glyph_emitter regression: fail");
    end
    $finish;
  end

endmodule
